// ----- rtl/core/ralm_pkg.sv -----
// Shared constants, state types and status struct of the RMS level meter.
package ralm_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned LEVEL_W        = 16;
  localparam int unsigned MAG_W          = SAMPLE_W + 1;
  localparam int unsigned SQ_W           = 2 * (SAMPLE_W - 1);
  localparam int unsigned RAD_W          = 2 * LEVEL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CALC,
    ST_OUT
  } meter_state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT,
    DS_DONE
  } dsq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } dsq_stat_t;

endpackage

// ----- rtl/core/ralm_in_if.sv -----
// Input channel: sample or tick command with valid/ready handshake.
interface ralm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [ralm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, cmd, sample, input ready);
  modport sink   (input valid, cmd, sample, output ready);
endinterface

// ----- rtl/core/ralm_out_if.sv -----
// Output channel: published level with valid/ready handshake.
interface ralm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ralm_pkg::LEVEL_W-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

// ----- rtl/core/ralm_divsqrt.sv -----
// Iterative divide then square root sharing one subtract/compare unit.
module ralm_divsqrt #(
  parameter int unsigned COUNT_BITS = ralm_pkg::COUNT_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [COUNT_BITS+ralm_pkg::SQ_W-1:0]        dividend_i,
  input  logic [COUNT_BITS-1:0]                       divisor_i,
  output logic [ralm_pkg::LEVEL_W-1:0]                root_o,
  output ralm_pkg::dsq_stat_t                         stat_o
);

  localparam int unsigned SUM_W  = COUNT_BITS + ralm_pkg::SQ_W;
  localparam int unsigned W      = (COUNT_BITS + 1 > 19) ? COUNT_BITS + 1 : 19;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned ROOT_W = ralm_pkg::LEVEL_W;
  localparam int unsigned RAD_W  = ralm_pkg::RAD_W;

  ralm_pkg::dsq_state_e state_q, state_d;
  logic [SUM_W-1:0]  num_q, num_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [W-1:0]      op_a, op_b;
  logic [W:0]        diff;
  logic              ge;

  // shared subtract/compare unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      ralm_pkg::DS_DIV: begin
        op_a = W'({rem_q[COUNT_BITS-1:0], num_q[SUM_W-1]});
        op_b = W'(divisor_i);
      end
      ralm_pkg::DS_SQRT: begin
        op_a = {rem_q[W-3:0], num_q[RAD_W-1 -: 2]};
        op_b = W'({root_q, 2'b01});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[W];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ralm_pkg::DS_IDLE: if (start_i) state_d = ralm_pkg::DS_DIV;
      ralm_pkg::DS_DIV:  if (step_q == '0) state_d = ralm_pkg::DS_SQRT;
      ralm_pkg::DS_SQRT: if (step_q == '0) state_d = ralm_pkg::DS_DONE;
      ralm_pkg::DS_DONE: state_d = ralm_pkg::DS_IDLE;
      default:           state_d = ralm_pkg::DS_IDLE;
    endcase
  end

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    unique case (state_q)
      ralm_pkg::DS_IDLE: begin
        if (start_i) begin
          num_d  = dividend_i;
          rem_d  = '0;
          root_d = '0;
          step_d = STEP_W'(SUM_W - 1);
        end
      end
      ralm_pkg::DS_DIV: begin
        num_d = {num_q[SUM_W-2:0], ge};
        if (step_q == '0) begin
          rem_d  = '0;
          step_d = STEP_W'(ROOT_W - 1);
        end else begin
          rem_d  = ge ? diff[W-1:0] : op_a;
          step_d = step_q - 1'b1;
        end
      end
      ralm_pkg::DS_SQRT: begin
        num_d  = {num_q[SUM_W-3:0], 2'b00};
        rem_d  = ge ? diff[W-1:0] : op_a;
        root_d = {root_q[ROOT_W-2:0], ge};
        if (step_q != '0) step_d = step_q - 1'b1;
      end
      default: begin
        num_d = num_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ralm_pkg::DS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = (state_q != ralm_pkg::DS_IDLE);
  assign stat_o.done = (state_q == ralm_pkg::DS_DONE);

endmodule

// ----- rtl/core/rms_audio_level_meter_unit.sv -----
// RMS audio level meter: accumulates squared samples, publishes floor(sqrt(mean)) on tick.
// Sample: magnitude registered on acceptance, squared and summed in the next cycle; ready again after that.
// Tick with samples pending: restoring divide of COUNT_BITS+30 steps, then a 16-step
// square root, both on one shared subtractor; level is registered when the root is done
// and held until taken. Tick with nothing pending: ignored, and ready stays high.
// Asynchronous active-low reset clears the sum, the count, the pending flag and all control.
module rms_audio_level_meter_unit #(
  parameter int unsigned COUNT_BITS = ralm_pkg::COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ralm_in_if.sink          item_i,
  ralm_out_if.source       level_o
);

  localparam int unsigned SUM_W = COUNT_BITS + ralm_pkg::SQ_W;
  localparam int unsigned MAG_W = ralm_pkg::MAG_W;

  ralm_pkg::meter_state_e state_q, state_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [COUNT_BITS-1:0]        count_q, count_d;
  logic                         pend_q, pend_d;
  logic [MAG_W-1:0]             mag_q, mag_d;
  logic [ralm_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [2*MAG_W-1:0]           prod;
  logic [ralm_pkg::LEVEL_W-1:0] root;
  ralm_pkg::dsq_stat_t          dsq_stat;
  logic                         accept;
  logic                         count_full;
  logic                         start;

  assign accept     = item_i.valid && item_i.ready;
  assign count_full = (count_q == {COUNT_BITS{1'b1}});
  assign start      = accept && item_i.cmd && pend_q && (count_q != '0);
  assign prod       = mag_q * mag_q;

  ralm_divsqrt #(
    .COUNT_BITS (COUNT_BITS)
  ) u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .root_o     (root),
    .stat_o     (dsq_stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ralm_pkg::ST_IDLE: begin
        if (accept && !item_i.cmd && !count_full) state_d = ralm_pkg::ST_SQUARE;
        else if (start)                            state_d = ralm_pkg::ST_CALC;
      end
      ralm_pkg::ST_SQUARE: state_d = ralm_pkg::ST_IDLE;
      ralm_pkg::ST_CALC:   if (dsq_stat.done) state_d = ralm_pkg::ST_OUT;
      ralm_pkg::ST_OUT:    if (level_o.ready) state_d = ralm_pkg::ST_IDLE;
      default:             state_d = ralm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    pend_d  = pend_q;
    mag_d   = mag_q;
    level_d = level_q;
    unique case (state_q)
      ralm_pkg::ST_IDLE: begin
        if (accept && !item_i.cmd && !count_full) begin
          mag_d   = item_i.sample[ralm_pkg::SAMPLE_W-1]
                    ? (MAG_W'(0) - {item_i.sample[ralm_pkg::SAMPLE_W-1], item_i.sample})
                    : {1'b0, item_i.sample};
          count_d = count_q + 1'b1;
          pend_d  = 1'b1;
        end
      end
      ralm_pkg::ST_SQUARE: sum_d = sum_q + SUM_W'(prod);
      ralm_pkg::ST_CALC: begin
        if (dsq_stat.done) begin
          level_d = root;
          sum_d   = '0;
          count_d = '0;
          pend_d  = 1'b0;
        end
      end
      default: begin
        level_d = level_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ralm_pkg::ST_IDLE;
      sum_q   <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    level_q <= level_d;
  end

  assign item_i.ready  = (state_q == ralm_pkg::ST_IDLE);
  assign level_o.valid = (state_q == ralm_pkg::ST_OUT);
  assign level_o.level = level_q;

  a_pend_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == (count_q != '0))
    else $error("pending flag disagrees with sample count");

  a_done_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsq_stat.done |-> state_q == ralm_pkg::ST_CALC)
    else $error("divide/sqrt finished outside calculation");

  a_calc_keeps_unit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ralm_pkg::ST_CALC |-> dsq_stat.busy)
    else $error("calculation waiting on idle divide/sqrt unit");

  a_level_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(level_o.valid) |-> $past(dsq_stat.done))
    else $error("level published without a finished calculation");

endmodule
